// ===== rtl/task_notification_bank_macros.svh =====
// Assertion macros shared by the notification bank RTL.
`ifndef TASK_NOTIFICATION_BANK_MACROS_SVH
`define TASK_NOTIFICATION_BANK_MACROS_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define TNB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tnb check failed");

// Check that the antecedent implies the consequent in the next cycle.
`define TNB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tnb check failed");

`endif

// ===== rtl/tnb_pkg.sv =====
// Shared types and constants of the task notification bank.
package tnb_pkg;

  localparam int unsigned TaskW = 4;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned ActW  = 3;
  localparam int unsigned ValW  = 32;

  localparam int DefaultNumTasks = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_NOTIFY     = 2'd0,
    CMD_WAIT_BEGIN = 2'd1,
    CMD_WAIT_END   = 2'd2
  } cmd_e;

  typedef enum logic [ActW-1:0] {
    ACT_OR        = 3'd0,
    ACT_INC       = 3'd1,
    ACT_OVERWRITE = 3'd2,
    ACT_TRYSET    = 3'd3,
    ACT_NONE      = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PENDING  = 2'd1,
    ST_RECEIVED = 2'd2
  } st_e;

  typedef struct packed {
    st_e             state;
    logic [ValW-1:0] value;
  } slot_t;

  localparam slot_t SlotReset = '{state: ST_IDLE, value: '0};

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== rtl/tnb_ctrl.sv =====
// Controller state machine of the task notification bank.
module tnb_ctrl import tnb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load = in_valid_i && (state_q == S_IDLE);
    cmd_o.exec = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.load) begin
            state_q <= S_EXEC;
          end
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (cmd_o.exec) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tnb_datapath.sv =====
// Slot memory, operand registers and update logic of the notification bank.
module tnb_datapath import tnb_pkg::*; #(
  parameter int NUM_TASKS = DefaultNumTasks
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic [CmdW-1:0]  cmd_in_i,
  input  logic [TaskW-1:0] task_req_i,
  input  logic [ActW-1:0]  action_i,
  input  logic [ValW-1:0]  value_i,
  input  logic [ValW-1:0]  clear_mask_i,
  output logic             success_o,
  output logic             woke_o,
  output logic [ValW-1:0]  value_out_o
);

  localparam int unsigned IdxW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CmpW = ((IdxW > TaskW) ? IdxW : TaskW) + 1;

  slot_t                 mem_q [NUM_TASKS];
  logic [NUM_TASKS-1:0]  valid_q;

  logic [CmdW-1:0]  cmd_q;
  logic [ActW-1:0]  act_q;
  logic [ValW-1:0]  val_q;
  logic [ValW-1:0]  mask_q;
  logic [IdxW-1:0]  idx_q;
  logic             in_range_q;
  slot_t            rd_q;
  logic             rd_valid_q;

  logic             success_q;
  logic             woke_q;
  logic [ValW-1:0]  value_out_q;

  logic [IdxW-1:0]  idx_d;
  logic             in_range_d;
  slot_t            cur;
  slot_t            wr_d;
  logic             we_d;
  logic             success_d;
  logic             woke_d;
  logic [ValW-1:0]  value_out_d;

  assign idx_d      = IdxW'(task_req_i);
  assign in_range_d = (CmpW'(task_req_i) < CmpW'(NUM_TASKS));
  assign cur        = rd_valid_q ? rd_q : SlotReset;

  always_comb begin
    wr_d        = cur;
    we_d        = 1'b0;
    success_d   = 1'b0;
    woke_d      = 1'b0;
    value_out_d = '0;
    if (in_range_q) begin
      case (cmd_e'(cmd_q))
        CMD_NOTIFY: begin
          success_d = 1'b1;
          case (act_e'(act_q))
            ACT_OR:        wr_d.value = cur.value | val_q;
            ACT_INC:       wr_d.value = cur.value + ValW'(1);
            ACT_OVERWRITE: wr_d.value = val_q;
            ACT_TRYSET: begin
              if (cur.state != ST_RECEIVED) begin
                wr_d.value = val_q;
              end else begin
                success_d = 1'b0;
              end
            end
            default: wr_d.value = cur.value;
          endcase
          woke_d     = (cur.state == ST_PENDING);
          wr_d.state = ST_RECEIVED;
          we_d       = 1'b1;
        end
        CMD_WAIT_BEGIN: begin
          if (cur.state == ST_RECEIVED) begin
            success_d = 1'b1;
          end else begin
            wr_d.value = cur.value & ~mask_q;
            wr_d.state = ST_PENDING;
            we_d       = 1'b1;
          end
        end
        CMD_WAIT_END: begin
          value_out_d = cur.value;
          if (cur.state == ST_RECEIVED) begin
            wr_d.value = cur.value & ~mask_q;
            success_d  = 1'b1;
          end
          wr_d.state = ST_IDLE;
          we_d       = 1'b1;
        end
        default: begin
          we_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.exec && we_d) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= cmd_in_i;
      act_q      <= action_i;
      val_q      <= value_i;
      mask_q     <= clear_mask_i;
      idx_q      <= idx_d;
      in_range_q <= in_range_d;
      if (in_range_d) begin
        rd_q       <= mem_q[idx_d];
        rd_valid_q <= valid_q[idx_d];
      end
    end
    if (cmd_i.exec) begin
      if (we_d) begin
        mem_q[idx_q] <= wr_d;
      end
      success_q   <= success_d;
      woke_q      <= woke_d;
      value_out_q <= value_out_d;
    end
  end

  assign success_o   = success_q;
  assign woke_o      = woke_q;
  assign value_out_o = value_out_q;

endmodule

// ===== rtl/task_notification_bank.sv =====
// Top level of the task notification bank.
//
//   channel | direction | handshake                | fields
//   in      | sink      | in_valid_i / in_stall_o  | cmd, task_req, action, value, clear_mask
//   out     | source    | out_valid_o / out_stall_i| success, woke, value_out
//
// The accept edge registers the slot read; in the execute state the block then
// performs the read-modify-write of the slot and loads the result register.
// A word is accepted while an earlier result still waits; its update holds
// until that result is taken. Reset clears per-slot valid bits at once, so
// no clearing pass is needed and the block accepts as soon as reset is released.
`include "task_notification_bank_macros.svh"

module task_notification_bank import tnb_pkg::*; #(
  parameter int NUM_TASKS = DefaultNumTasks
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [TaskW-1:0] task_req_i,
  input  logic [ActW-1:0]  action_i,
  input  logic [ValW-1:0]  value_i,
  input  logic [ValW-1:0]  clear_mask_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             success_o,
  output logic             woke_o,
  output logic [ValW-1:0]  value_out_o
);

  ctrl_cmd_t ctrl_cmd;

  tnb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctrl_cmd)
  );

  tnb_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .cmd_in_i     (cmd_i),
    .task_req_i   (task_req_i),
    .action_i     (action_i),
    .value_i      (value_i),
    .clear_mask_i (clear_mask_i),
    .success_o    (success_o),
    .woke_o       (woke_o),
    .value_out_o  (value_out_o)
  );

  `TNB_ASSERT_NEXT(a_accept_blocks, in_valid_i && !in_stall_o, in_stall_o)
  `TNB_ASSERT_NEXT(a_exec_shows, ctrl_cmd.exec, out_valid_o)
  `TNB_ASSERT_SAME(a_load_exec_apart, 1'b1, !(ctrl_cmd.load && ctrl_cmd.exec))
  `TNB_ASSERT_SAME(a_woke_ok, out_valid_o && woke_o, success_o)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the task notification bank: directed and random commands.
`timescale 1ns / 1ps

module testbench;
  import tnb_pkg::*;

  localparam int NumSlots = DefaultNumTasks;
  localparam int RandomWords = 1300;
  localparam int CalmWords = 200;
  localparam int CycleLimit = 500000;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic [ActW-1:0] ActSpareFirst = 3'd5;
  localparam logic [ActW-1:0] ActSpareLast = 3'd7;

  typedef struct packed {
    logic            success;
    logic            woke;
    logic [ValW-1:0] value_out;
  } reply_t;

  class notify_scoreboard;
    logic [ValW-1:0] slot_val [NumSlots];
    st_e             slot_st [NumSlots];
    reply_t          expected_replies [$];
    int              errors;
    int              checked;
    int              wakes;
    int              refusals;

    function new();
      foreach (slot_val[i]) begin
        slot_val[i] = '0;
        slot_st[i] = ST_IDLE;
      end
      errors = 0;
      checked = 0;
      wakes = 0;
      refusals = 0;
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    function void note_command(logic [CmdW-1:0] cmd, logic [TaskW-1:0] idx,
                               logic [ActW-1:0] act, logic [ValW-1:0] val,
                               logic [ValW-1:0] mask);
      reply_t r;
      st_e    st;
      r = '0;
      if (int'(idx) < NumSlots) begin
        st = slot_st[idx];
        case (cmd)
          CMD_NOTIFY: begin
            r.success = 1'b1;
            case (act)
              ACT_OR:        slot_val[idx] = slot_val[idx] | val;
              ACT_INC:       slot_val[idx] = slot_val[idx] + 1'b1;
              ACT_OVERWRITE: slot_val[idx] = val;
              ACT_TRYSET: begin
                if (st != ST_RECEIVED) slot_val[idx] = val;
                else r.success = 1'b0;
              end
              default: ;
            endcase
            r.woke = (st == ST_PENDING);
            slot_st[idx] = ST_RECEIVED;
            if (r.woke) wakes++;
            if (!r.success) refusals++;
          end
          CMD_WAIT_BEGIN: begin
            if (st == ST_RECEIVED) begin
              r.success = 1'b1;
            end else begin
              slot_val[idx] = slot_val[idx] & ~mask;
              slot_st[idx] = ST_PENDING;
            end
          end
          CMD_WAIT_END: begin
            r.value_out = slot_val[idx];
            if (st == ST_RECEIVED) begin
              slot_val[idx] = slot_val[idx] & ~mask;
              r.success = 1'b1;
            end
            slot_st[idx] = ST_IDLE;
          end
          default: ;
        endcase
      end
      expected_replies.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_result(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch("result word arrived with none expected");
      end else begin
        want = expected_replies.pop_front();
        checked++;
        if (got.success !== want.success)
          report_mismatch($sformatf("result %0d success %b, expected %b",
                                    checked, got.success, want.success));
        if (got.woke !== want.woke)
          report_mismatch($sformatf("result %0d woke %b, expected %b",
                                    checked, got.woke, want.woke));
        if (got.value_out !== want.value_out)
          report_mismatch($sformatf("result %0d value_out %h, expected %h",
                                    checked, got.value_out, want.value_out));
      end
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [CmdW-1:0]  cmd_i = '0;
  logic [TaskW-1:0] task_req_i = '0;
  logic [ActW-1:0]  action_i = '0;
  logic [ValW-1:0]  value_i = '0;
  logic [ValW-1:0]  clear_mask_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             success_o;
  logic             woke_o;
  logic [ValW-1:0]  value_out_o;

  notify_scoreboard sb = new();
  int  words_sent = 0;
  int  cycles = 0;
  int  idle_pct = 20;
  int  stall_pct = 20;
  int  stall_left = 0;
  int  pauses = 0;
  bit  calm = 1'b0;

  task_notification_bank #(.NUM_TASKS(NumSlots)) dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, sb.outstanding());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result({success_o, woke_o, value_out_o});
      if (calm) begin
        stall_left = 0;
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(13, 1) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [ValW-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(31);
      3: return ~(32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ActW-1:0] rand_action();
    if ($urandom_range(9) < 8) return ActW'($urandom_range(4));
    return ActW'($urandom_range(ActSpareLast, ActSpareFirst));
  endfunction

  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [TaskW-1:0] idx,
                           input logic [ActW-1:0] act, input logic [ValW-1:0] val,
                           input logic [ValW-1:0] mask);
    if (!calm && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    task_req_i <= idx;
    action_i <= act;
    value_i <= val;
    clear_mask_i <= mask;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, idx, act, val, mask);
    words_sent++;
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    pauses++;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic wait_sequence();
    logic [TaskW-1:0] idx;
    int               notes;
    idx = TaskW'($urandom_range(NumSlots - 1));
    if ($urandom_range(3) == 0) send_word(CMD_NOTIFY, idx, rand_action(), rand_word(), '0);
    send_word(CMD_WAIT_BEGIN, idx, rand_action(), rand_word(), rand_word());
    if ($urandom_range(4) == 0) send_word(CMD_WAIT_BEGIN, idx, rand_action(), rand_word(),
                                          rand_word());
    notes = $urandom_range(3);
    repeat (notes) begin
      if ($urandom_range(5) == 0)
        send_word(CmdW'($urandom_range(3)), TaskW'($urandom), rand_action(), rand_word(),
                  rand_word());
      send_word(CMD_NOTIFY, idx, rand_action(), rand_word(), rand_word());
    end
    send_word(CMD_WAIT_END, idx, rand_action(), rand_word(), rand_word());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_WAIT_END, 4'd0, ACT_OR, '0, '0);
    send_word(CMD_NOTIFY, 4'd15, ACT_OVERWRITE, '1, '0);
    send_word(CMD_NOTIFY, 4'd15, ACT_INC, '0, '1);
    send_word(CMD_NOTIFY, 4'd15, ACT_OR, 32'hA5A5_A5A5, '0);
    send_word(CMD_NOTIFY, 4'd15, ACT_TRYSET, 32'h0000_0001, '0);
    send_word(CMD_WAIT_BEGIN, 4'd15, ACT_OR, '0, '1);
    send_word(CMD_WAIT_END, 4'd15, ACT_OR, '0, 32'hFFFF_0000);
    send_word(CMD_WAIT_BEGIN, 4'd3, ACT_OR, '0, '1);
    send_word(CMD_WAIT_BEGIN, 4'd3, ACT_OR, '0, '0);
    send_word(CMD_NOTIFY, 4'd3, ACT_TRYSET, 32'h5A5A_5A5A, '0);
    send_word(CMD_WAIT_END, 4'd3, ACT_OR, '0, '1);
    send_word(CMD_WAIT_BEGIN, 4'd4, ACT_NONE, '1, 32'h0F0F_0F0F);
    send_word(CMD_WAIT_END, 4'd4, ACT_NONE, '1, '1);
    send_word(CMD_NOTIFY, 4'd7, ACT_NONE, '1, '1);
    for (int a = ActSpareFirst; a <= ActSpareLast; a++)
      send_word(CMD_NOTIFY, TaskW'(a + 3), ActW'(a), '1, '1);
    send_word(CmdUnused, 4'd7, ActSpareLast, '1, '1);
    send_word(CMD_WAIT_END, 4'd7, ACT_OR, '0, 32'h8000_0001);
    send_word(CMD_WAIT_BEGIN, 4'd9, ACT_OR, '0, '1);
    send_word(CMD_NOTIFY, 4'd9, ACT_INC, '0, '0);
    send_word(CMD_WAIT_END, 4'd9, ACT_OR, '0, '0);
    drain_replies();

    while (words_sent < RandomWords) begin
      if (words_sent >= RandomWords - CalmWords) calm = 1'b1;
      if ($urandom_range(49) == 0) begin
        case ($urandom_range(3))
          0: idle_pct = 0;
          1: idle_pct = 10;
          2: idle_pct = 30;
          default: idle_pct = 60;
        endcase
        stall_pct = 15 * $urandom_range(3);
      end
      if ($urandom_range(9) < 7) begin
        wait_sequence();
      end else begin
        send_word(CmdW'($urandom_range(3)), TaskW'($urandom), rand_action(), rand_word(),
                  rand_word());
      end
      if (!calm && $urandom_range(149) == 0) drain_replies();
    end

    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d command words over %0d slots, %0d drain pauses.",
             words_sent, NumSlots, pauses);
    $display("Compared %0d results: %0d wake-ups, %0d refused try-sets.",
             sb.checked, sb.wakes, sb.refusals);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== task_notification_bank.f =====
+incdir+rtl
rtl/tnb_pkg.sv
rtl/tnb_ctrl.sv
rtl/tnb_datapath.sv
rtl/task_notification_bank.sv
sim/testbench.sv
